// ===== hw/rtl/bmpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpe_pkg
// Shared constants, types and header lookup for the 24-bit BMP encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmpe_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_W      = 24;
  localparam int DIM_W      = 7;
  localparam int RB_W       = 8;
  localparam int POS_W      = 14;
  localparam int HDR_BYTES  = 54;
  localparam int INFO_BYTES = 40;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FETCH  = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {SRC_HDR, SRC_PIX, SRC_PAD} src_e;
  typedef enum logic [1:0] {CH_BLUE, CH_GREEN, CH_RED} chan_e;

  typedef struct packed {
    logic        valid;
    logic        last;
    src_e        src;
    chan_e       chan;
    logic [7:0]  hdr;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if ({1'b0, v} > maxv) r = maxv[DIM_W-1:0];
    else r = v;
    return r;
  endfunction

  function automatic logic [7:0] header_byte(input logic [5:0]       pos,
                                             input logic [POS_W-1:0] size,
                                             input logic [DIM_W-1:0] w,
                                             input logic [DIM_W-1:0] h);
    logic [31:0] s;
    logic [7:0]  b;
    s = {{(32-POS_W){1'b0}}, size};
    unique case (pos)
      6'd0:    b = 8'h42;
      6'd1:    b = 8'h4D;
      6'd2:    b = s[7:0];
      6'd3:    b = s[15:8];
      6'd4:    b = s[23:16];
      6'd5:    b = s[31:24];
      6'd10:   b = 8'(HDR_BYTES);
      6'd14:   b = 8'(INFO_BYTES);
      6'd18:   b = {1'b0, w};
      6'd22:   b = {1'b0, h};
      6'd26:   b = 8'd1;
      6'd28:   b = 8'd24;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmpe_ram.sv =====
// ----------------------------------------------------------------------------
// bmpe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmpe_byte_seq.sv =====
// ----------------------------------------------------------------------------
// bmpe_byte_seq
// File byte sequencer: header lookup, row/column/channel walk, pixel address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmpe_byte_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fetch_i,
  input  wire logic [bmpe_pkg::DIM_W-1:0]     width_i,
  input  wire logic [bmpe_pkg::DIM_W-1:0]     height_i,
  output logic      [bmpe_pkg::ADDR_W-1:0]    raddr_o,
  output bmpe_pkg::res_t                      res_o
);
  import bmpe_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [RB_W-1:0]  rbyte_q, rbyte_d;
  chan_e            chan_q, chan_d;
  res_t             res_q, res_d;

  logic [DIM_W+1:0]       w3;
  logic [DIM_W+1:0]       rb_full;
  logic [RB_W-1:0]        rb;
  logic [DIM_W+RB_W-1:0]  area;
  logic [POS_W-1:0]       size;
  logic                   last;
  logic [ROW_W-1:0]       top_row;
  logic                   in_hdr;

  assign w3      = {1'b0, width_i, 1'b0} + {2'b00, width_i};
  assign rb_full = (w3 + (DIM_W+2)'(3)) & ~(DIM_W+2)'(3);
  assign rb      = rb_full[RB_W-1:0];
  assign area    = height_i * rb;
  assign size    = POS_W'(area) + POS_W'(HDR_BYTES);
  assign last    = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, size};
  assign top_row = ROW_W'(height_i - DIM_W'(1));
  assign in_hdr  = pos_q < POS_W'(HDR_BYTES);
  assign raddr_o = {row_q, col_q};

  always_comb begin
    pos_d   = pos_q;
    row_d   = row_q;
    col_d   = col_q;
    rbyte_d = rbyte_q;
    chan_d  = chan_q;
    res_d   = '0;
    if (fetch_i) begin
      res_d.valid = 1'b1;
      res_d.last  = last;
      res_d.chan  = chan_q;
      if (in_hdr) begin
        res_d.src = SRC_HDR;
        res_d.hdr = header_byte(pos_q[5:0], size, width_i, height_i);
        if (pos_q == POS_W'(HDR_BYTES - 1)) begin
          row_d   = top_row;
          col_d   = '0;
          rbyte_d = '0;
          chan_d  = CH_BLUE;
        end
      end else begin
        res_d.src = ({1'b0, rbyte_q} < w3) ? SRC_PIX : SRC_PAD;
        if (chan_q == CH_RED) begin
          chan_d = CH_BLUE;
          col_d  = col_q + COL_W'(1);
        end else begin
          chan_d = chan_e'(chan_q + 2'd1);
        end
        if (({1'b0, rbyte_q} + (RB_W+1)'(1)) >= {1'b0, rb}) begin
          rbyte_d = '0;
          col_d   = '0;
          chan_d  = CH_BLUE;
          row_d   = (row_q == '0) ? top_row : row_q - ROW_W'(1);
        end else begin
          rbyte_d = rbyte_q + RB_W'(1);
        end
      end
      if (last) begin
        pos_d   = '0;
        row_d   = top_row;
        col_d   = '0;
        rbyte_d = '0;
        chan_d  = CH_BLUE;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      row_q   <= ROW_W'(MAX_HEIGHT - 1);
      col_q   <= '0;
      rbyte_q <= '0;
      chan_q  <= CH_BLUE;
      res_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      row_q   <= row_d;
      col_q   <= col_d;
      rbyte_q <= rbyte_d;
      chan_q  <= chan_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fetch_i && last) |=> (pos_q == '0 && rbyte_q == '0))
    else $error("position not restarted after last byte");

  a_row_start_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rbyte_q == '0) |-> (col_q == '0 && chan_q == CH_BLUE))
    else $error("column or channel not aligned at row start");

  a_strobe_follows_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_i |=> res_q.valid)
    else $error("no result after fetch");

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_bmp_file_encoder.sv =====
// ----------------------------------------------------------------------------
// rgb_to_bmp_file_encoder
// Loads RGB pixels into a pixel RAM and streams a 24-bit BMP file bytewise.
//
//   channel  ports                                  handshake
//   command  start_i busy_o command_i red/green/blue_i  start_i && !busy_o
//   result   valid_o file_byte_o last_byte_o        valid_o, one cycle
//   config   cfg_we_i cfg_index_i cfg_data_i        cfg_we_i
//
// One transaction per cycle; busy_o stays low.
// A fetch returns its byte in the cycle after acceptance (pixel RAM read).
// A load writes the pixel RAM at the accepting edge; no result.
// Reset clears counters and sets 64x64; pixel RAM is undefined until loaded.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_bmp_file_encoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        command_i,
  input  wire logic [7:0]                  red_i,
  input  wire logic [7:0]                  green_i,
  input  wire logic [7:0]                  blue_i,
  output logic                             valid_o,
  output logic      [7:0]                  file_byte_o,
  output logic                             last_byte_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [bmpe_pkg::DIM_W-1:0]  cfg_data_i
);
  import bmpe_pkg::*;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [COL_W-1:0]  lcol_q, lcol_d;
  logic [ROW_W-1:0]  lrow_q, lrow_d;
  logic              accept, load, fetch;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;
  res_t              res;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign load   = accept && (command_i == CMD_LOAD);
  assign fetch  = accept && (command_i == CMD_FETCH);
  assign eff_w  = clamp_dim(width_q, (DIM_W+1)'(MAX_WIDTH));
  assign eff_h  = clamp_dim(height_q, (DIM_W+1)'(MAX_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(64);
      height_q <= DIM_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    lcol_d = lcol_q;
    lrow_d = lrow_q;
    if (load) begin
      if (({1'b0, lcol_q} + (COL_W+1)'(1)) >= (COL_W+1)'(eff_w)) begin
        lcol_d = '0;
        lrow_d = (({1'b0, lrow_q} + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h)) ?
                 '0 : lrow_q + ROW_W'(1);
      end else begin
        lcol_d = lcol_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcol_q <= '0;
      lrow_q <= '0;
    end else begin
      lcol_q <= lcol_d;
      lrow_q <= lrow_d;
    end
  end

  bmpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i ({lrow_q, lcol_q}),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (fetch),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bmpe_byte_seq u_byte_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fetch_i  (fetch),
    .width_i  (eff_w),
    .height_i (eff_h),
    .raddr_o  (raddr),
    .res_o    (res)
  );

  always_comb begin
    file_byte_o = 8'd0;
    case (res.src)
      SRC_HDR: file_byte_o = res.hdr;
      SRC_PIX: begin
        case (res.chan)
          CH_GREEN: file_byte_o = rdata[15:8];
          CH_RED:   file_byte_o = rdata[23:16];
          default:  file_byte_o = rdata[7:0];
        endcase
      end
      default: file_byte_o = 8'd0;
    endcase
  end

  assign valid_o     = res.valid;
  assign last_byte_o = res.valid && res.last;

endmodule

`default_nettype wire
